FILE: hw/rtl/cfm_pkg.sv
// Package: codes, modes, register indexes, widths and defaults of the cell fault monitor.
package cfm_pkg;

   localparam int MAX_CELLS_DEF  = 16;
   localparam int TIMER_BITS_DEF = 24;

   localparam int CODE_W   = 3;
   localparam int MODE_W   = 2;
   localparam int INDEX_W  = 4;
   localparam int SAMPLE_W = 16;
   localparam int COUNT_W  = 5;
   localparam int DELAY_W  = 24;
   localparam int CSR_W    = 24;
   localparam int CSR_IDX_W = 3;

   localparam logic [CODE_W-1:0] CODE_OK   = 3'd0;
   localparam logic [CODE_W-1:0] CODE_OV   = 3'd1;
   localparam logic [CODE_W-1:0] CODE_UV   = 3'd2;
   localparam logic [CODE_W-1:0] CODE_OT   = 3'd3;
   localparam logic [CODE_W-1:0] CODE_LINK = 3'd4;

   localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_TICK   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_CELL_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_VOLT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_VOLT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_TEMP   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FAULT_DLY  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_WARN_DLY   = 3'd5;

   localparam logic [COUNT_W-1:0]  RST_CELL_COUNT = 5'd16;
   localparam logic [SAMPLE_W-1:0] RST_MIN_VOLT   = 16'd0;
   localparam logic [SAMPLE_W-1:0] RST_MAX_VOLT   = 16'hFFFF;
   localparam logic [SAMPLE_W-1:0] RST_MAX_TEMP   = 16'hFFFF;
   localparam logic [DELAY_W-1:0]  RST_FAULT_DLY  = 24'd15000;
   localparam logic [DELAY_W-1:0]  RST_WARN_DLY   = 24'd2500;

   // timers: fault of class c at 2c, warning at 2c+1
   localparam int NUM_CLASSES = 3;
   localparam int NUM_TIMERS  = 2 * NUM_CLASSES;
   localparam logic [CODE_W-1:0] CLASS_CODES [NUM_CLASSES] = '{CODE_UV, CODE_OV, CODE_OT};

endpackage

FILE: hw/rtl/cfm_req_if.sv
// Interface: request channel carrying sample, tick and read transactions.
interface cfm_req_if
   import cfm_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [MODE_W-1:0]   mode;
   logic [INDEX_W-1:0]  cell_index;
   logic [SAMPLE_W-1:0] cell_voltage;
   logic [SAMPLE_W-1:0] cell_temperature;
   logic                link_ok;

   modport source (output valid, mode, cell_index, cell_voltage, cell_temperature, link_ok,
                   input ready);
   modport sink   (input valid, mode, cell_index, cell_voltage, cell_temperature, link_ok,
                   output ready);
endinterface

FILE: hw/rtl/cfm_rsp_if.sv
// Interface: response channel carrying one result transaction per request.
interface cfm_rsp_if
   import cfm_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [CODE_W-1:0] cell_code;
   logic [CODE_W-1:0] warning_code;
   logic [CODE_W-1:0] fault_code;
   logic              loop_closed;
   logic              undervolt_seen;
   logic              overvolt_seen;
   logic              overtemp_seen;
   logic              warning_fired;
   logic              fault_fired;
   logic              index_ignored;

   modport source (output valid, cell_code, warning_code, fault_code, loop_closed,
                   undervolt_seen, overvolt_seen, overtemp_seen, warning_fired,
                   fault_fired, index_ignored,
                   input ready);
   modport sink   (input valid, cell_code, warning_code, fault_code, loop_closed,
                   undervolt_seen, overvolt_seen, overtemp_seen, warning_fired,
                   fault_fired, index_ignored,
                   output ready);
endinterface

FILE: hw/rtl/cell_fault_monitor_unit.sv
// A request transaction is taken into the input stage register; its response is loaded
// into the response register when the input stage advances.
// Throughput: one transaction per cycle unless the response channel stalls; the cell
// tables, timers and class detection are all updated as the response register loads.
// Reset (synchronous, active high): cell codes, warning and fault tables and timers
// cleared, safety loop closed, registers at defaults; no clearing pass.
module cell_fault_monitor_unit
   import cfm_pkg::*;
#(
   parameter int MAX_CELLS  = MAX_CELLS_DEF,
   parameter int TIMER_BITS = TIMER_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   cfm_req_if.sink              req_if,
   cfm_rsp_if.source            rsp_if,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wr_data
);

   localparam int IW     = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
   localparam int CNT_W  = $clog2(MAX_CELLS + 1);
   localparam int CMP_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

   // configuration registers
   logic [COUNT_W-1:0]  cell_count_ff;
   logic [SAMPLE_W-1:0] min_volt_ff;
   logic [SAMPLE_W-1:0] max_volt_ff;
   logic [SAMPLE_W-1:0] max_temp_ff;
   logic [DELAY_W-1:0]  fault_dly_ff;
   logic [DELAY_W-1:0]  warn_dly_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_count_ff <= RST_CELL_COUNT;
         min_volt_ff   <= RST_MIN_VOLT;
         max_volt_ff   <= RST_MAX_VOLT;
         max_temp_ff   <= RST_MAX_TEMP;
         fault_dly_ff  <= RST_FAULT_DLY;
         warn_dly_ff   <= RST_WARN_DLY;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_CELL_COUNT: cell_count_ff <= csr_wr_data[COUNT_W-1:0];
            REG_MIN_VOLT:   min_volt_ff   <= csr_wr_data[SAMPLE_W-1:0];
            REG_MAX_VOLT:   max_volt_ff   <= csr_wr_data[SAMPLE_W-1:0];
            REG_MAX_TEMP:   max_temp_ff   <= csr_wr_data[SAMPLE_W-1:0];
            REG_FAULT_DLY:  fault_dly_ff  <= csr_wr_data[DELAY_W-1:0];
            REG_WARN_DLY:   warn_dly_ff   <= csr_wr_data[DELAY_W-1:0];
            default: ;
         endcase
      end
   end

   // input stage
   logic                stg_valid_ff;
   logic [MODE_W-1:0]   stg_mode_ff;
   logic [INDEX_W-1:0]  stg_index_ff;
   logic [SAMPLE_W-1:0] stg_volt_ff;
   logic [SAMPLE_W-1:0] stg_temp_ff;
   logic                stg_link_ff;

   logic rsp_valid_ff;
   logic advance;

   assign advance      = stg_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !stg_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         stg_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         stg_mode_ff  <= req_if.mode;
         stg_index_ff <= req_if.cell_index;
         stg_volt_ff  <= req_if.cell_voltage;
         stg_temp_ff  <= req_if.cell_temperature;
         stg_link_ff  <= req_if.link_ok;
      end
   end

   // state
   logic [CODE_W-1:0]     codes_ff [MAX_CELLS];
   logic [CODE_W-1:0]     warn_tab_ff [MAX_CELLS];
   logic [CODE_W-1:0]     fault_tab_ff [MAX_CELLS];
   logic [CODE_W-1:0]     codes_in [MAX_CELLS];
   logic [CODE_W-1:0]     warn_tab_in [MAX_CELLS];
   logic [CODE_W-1:0]     fault_tab_in [MAX_CELLS];
   logic [TIMER_BITS-1:0] cnt_ff [NUM_TIMERS];
   logic [TIMER_BITS-1:0] cnt_in [NUM_TIMERS];
   logic [NUM_TIMERS-1:0] run_ff;
   logic [NUM_TIMERS-1:0] run_in;
   logic                  loop_ff;
   logic                  loop_in;

   // item decode
   logic [CMP_W-1:0]    monitored;
   logic [CMP_W-1:0]    cc_ext;
   logic [CMP_W-1:0]    idx_ext;
   logic [IW+INDEX_W-1:0] idx_wide;
   logic [IW-1:0]       cidx;
   logic                addressed;
   logic                ignored;
   logic                do_sample;
   logic                is_tick;

   assign cc_ext    = CMP_W'(cell_count_ff);
   assign monitored = (cc_ext > CMP_W'(MAX_CELLS)) ? CMP_W'(MAX_CELLS) : cc_ext;
   assign idx_ext   = CMP_W'(stg_index_ff);
   assign idx_wide  = {{IW{1'b0}}, stg_index_ff};
   assign cidx      = idx_wide[IW-1:0];
   assign addressed = (stg_mode_ff == MODE_SAMPLE) || (stg_mode_ff == MODE_READ);
   assign ignored   = addressed && (idx_ext >= monitored);
   assign do_sample = advance && (stg_mode_ff == MODE_SAMPLE) && !ignored;
   assign is_tick   = advance && (stg_mode_ff == MODE_TICK);

   // effective delays, modulo timer width, zero acts as one
   logic [TIMER_BITS+DELAY_W-1:0] fault_dly_wide;
   logic [TIMER_BITS+DELAY_W-1:0] warn_dly_wide;
   logic [TIMER_BITS-1:0]         fault_load;
   logic [TIMER_BITS-1:0]         warn_load;

   assign fault_dly_wide = {{TIMER_BITS{1'b0}}, fault_dly_ff};
   assign warn_dly_wide  = {{TIMER_BITS{1'b0}}, warn_dly_ff};
   assign fault_load = (fault_dly_wide[TIMER_BITS-1:0] == '0) ? TIMER_BITS'(1)
                                                             : fault_dly_wide[TIMER_BITS-1:0];
   assign warn_load  = (warn_dly_wide[TIMER_BITS-1:0] == '0) ? TIMER_BITS'(1)
                                                            : warn_dly_wide[TIMER_BITS-1:0];

   // tick evaluation
   logic [NUM_TIMERS-1:0] expire;
   logic                  w_fire;
   logic                  f_fire;

   always_comb begin
      w_fire = 1'b0;
      f_fire = 1'b0;
      for (int t = 0; t < NUM_TIMERS; t++) begin
         expire[t] = run_ff[t] && (cnt_ff[t] <= TIMER_BITS'(1));
      end
      for (int c = 0; c < NUM_CLASSES; c++) begin
         f_fire = f_fire | expire[2*c];
         w_fire = w_fire | expire[2*c+1];
      end
      f_fire = f_fire && is_tick;
      w_fire = w_fire && is_tick;
   end

   // cell and table update
   always_comb begin
      codes_in     = codes_ff;
      warn_tab_in  = warn_tab_ff;
      fault_tab_in = fault_tab_ff;
      loop_in      = loop_ff;
      if (do_sample) begin
         if (!stg_link_ff) begin
            codes_in[cidx]    = CODE_LINK;
            warn_tab_in[cidx] = CODE_LINK;
         end else begin
            if ((codes_ff[cidx] == CODE_LINK) || (codes_ff[cidx] == CODE_OK)) begin
               warn_tab_in[cidx] = CODE_OK;
            end
            if (stg_volt_ff < min_volt_ff) begin
               codes_in[cidx] = CODE_UV;
            end else if (stg_volt_ff > max_volt_ff) begin
               codes_in[cidx] = CODE_OV;
            end else if (stg_temp_ff > max_temp_ff) begin
               codes_in[cidx] = CODE_OT;
            end else begin
               codes_in[cidx]     = CODE_OK;
               warn_tab_in[cidx]  = CODE_OK;
               fault_tab_in[cidx] = CODE_OK;
            end
         end
      end else begin
         if (w_fire) begin
            warn_tab_in = codes_ff;
         end
         if (f_fire) begin
            fault_tab_in = codes_ff;
            loop_in      = 1'b0;
         end
      end
   end

   // class detection over monitored cells
   logic [MAX_CELLS-1:0]   mon_mask;
   logic [MAX_CELLS-1:0]   match [NUM_CLASSES];
   logic [NUM_CLASSES-1:0] seen;

   always_comb begin
      for (int i = 0; i < MAX_CELLS; i++) begin
         mon_mask[i] = CMP_W'(i) < monitored;
      end
      for (int c = 0; c < NUM_CLASSES; c++) begin
         for (int i = 0; i < MAX_CELLS; i++) begin
            match[c][i] = mon_mask[i] && (codes_in[i] == CLASS_CODES[c]);
         end
         seen[c] = |match[c];
      end
   end

   // timer update
   always_comb begin
      cnt_in = cnt_ff;
      run_in = run_ff;
      if (do_sample) begin
         for (int c = 0; c < NUM_CLASSES; c++) begin
            if (seen[c]) begin
               if (!run_ff[2*c]) begin
                  run_in[2*c] = 1'b1;
                  cnt_in[2*c] = fault_load;
               end
               if (!run_ff[2*c+1]) begin
                  run_in[2*c+1] = 1'b1;
                  cnt_in[2*c+1] = warn_load;
               end
            end else begin
               run_in[2*c]   = 1'b0;
               cnt_in[2*c]   = '0;
               run_in[2*c+1] = 1'b0;
               cnt_in[2*c+1] = '0;
            end
         end
      end else if (is_tick) begin
         for (int t = 0; t < NUM_TIMERS; t++) begin
            if (run_ff[t]) begin
               if (cnt_ff[t] != '0) begin
                  cnt_in[t] = cnt_ff[t] - TIMER_BITS'(1);
               end
               if (expire[t]) begin
                  run_in[t] = 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_CELLS; i++) begin
            codes_ff[i]     <= CODE_OK;
            warn_tab_ff[i]  <= CODE_OK;
            fault_tab_ff[i] <= CODE_OK;
         end
         for (int t = 0; t < NUM_TIMERS; t++) begin
            cnt_ff[t] <= '0;
         end
         run_ff  <= '0;
         loop_ff <= 1'b1;
      end else begin
         codes_ff     <= codes_in;
         warn_tab_ff  <= warn_tab_in;
         fault_tab_ff <= fault_tab_in;
         cnt_ff       <= cnt_in;
         run_ff       <= run_in;
         loop_ff      <= loop_in;
      end
   end

   // response register
   logic              show;
   logic [CODE_W-1:0] rsp_cell_ff;
   logic [CODE_W-1:0] rsp_warn_ff;
   logic [CODE_W-1:0] rsp_fault_ff;
   logic              rsp_loop_ff;
   logic              rsp_uv_ff;
   logic              rsp_ov_ff;
   logic              rsp_ot_ff;
   logic              rsp_wfired_ff;
   logic              rsp_ffired_ff;
   logic              rsp_ignored_ff;

   assign show = addressed && !ignored;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_cell_ff    <= show ? codes_in[cidx] : CODE_OK;
         rsp_warn_ff    <= show ? warn_tab_in[cidx] : CODE_OK;
         rsp_fault_ff   <= show ? fault_tab_in[cidx] : CODE_OK;
         rsp_loop_ff    <= loop_in;
         rsp_uv_ff      <= seen[0];
         rsp_ov_ff      <= seen[1];
         rsp_ot_ff      <= seen[2];
         rsp_wfired_ff  <= w_fire;
         rsp_ffired_ff  <= f_fire;
         rsp_ignored_ff <= ignored;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.cell_code      = rsp_cell_ff;
   assign rsp_if.warning_code   = rsp_warn_ff;
   assign rsp_if.fault_code     = rsp_fault_ff;
   assign rsp_if.loop_closed    = rsp_loop_ff;
   assign rsp_if.undervolt_seen = rsp_uv_ff;
   assign rsp_if.overvolt_seen  = rsp_ov_ff;
   assign rsp_if.overtemp_seen  = rsp_ot_ff;
   assign rsp_if.warning_fired  = rsp_wfired_ff;
   assign rsp_if.fault_fired    = rsp_ffired_ff;
   assign rsp_if.index_ignored  = rsp_ignored_ff;

`ifndef NO_ASSERTIONS
   // safety loop, once open, stays open until reset
   a_loop_latched: assert property (@(posedge clock) disable iff (reset)
      !loop_ff |=> !loop_ff)
      else $error("safety loop closed again without reset");

   // a running timer never holds a zero count
   a_run_nonzero: assert property (@(posedge clock) disable iff (reset)
      (run_ff[0] |-> cnt_ff[0] != '0) and (run_ff[1] |-> cnt_ff[1] != '0) and
      (run_ff[2] |-> cnt_ff[2] != '0) and (run_ff[3] |-> cnt_ff[3] != '0) and
      (run_ff[4] |-> cnt_ff[4] != '0) and (run_ff[5] |-> cnt_ff[5] != '0))
      else $error("running timer with zero count");

   // a fault firing is reported with the loop open
   a_fault_opens: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ffired_ff) |-> !rsp_loop_ff)
      else $error("fault fired while loop reported closed");

   // an ignored transaction returns empty cell fields
   a_ignored_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ignored_ff) |->
      (rsp_cell_ff == CODE_OK && rsp_warn_ff == CODE_OK && rsp_fault_ff == CODE_OK))
      else $error("ignored transaction returned cell entries");

   // a stalled input stage keeps its transaction
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (stg_valid_ff && !advance) |=> (stg_valid_ff && $stable(stg_mode_ff)
                                      && $stable(stg_index_ff)))
      else $error("input stage lost a stalled transaction");
`endif

endmodule
